// ===== rtl/core/group_order_reverser_assert.svh =====
// Assertion macros for the group order reverser checks
`ifndef GROUP_ORDER_REVERSER_ASSERT_SVH
`define GROUP_ORDER_REVERSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define GOR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("group_order_reverser: check failed");

// next-cycle implication, disabled in reset
`define GOR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("group_order_reverser: check failed");

`endif

// ===== rtl/core/gor_pkg.sv =====
package gor_pkg;

    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 5;
    localparam int IDX_MAX_W = 6;

    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 5'd16;

    typedef struct packed {
        logic                 bank;
        logic [IDX_MAX_W-1:0] top;
        logic                 last;
    } desc_t;

    typedef struct packed {
        logic tail;
        logic last;
    } tag_t;

endpackage

// ===== rtl/core/group_order_reverser.sv =====
// Group order reverser: reverses a stream of list values in groups.
// Input queue side: drive value and end_of_list with push; the item is taken
// at a clock edge where push is high and full is low. Result queue side:
// while empty is low the oldest result is on out_value, group_done and
// list_done; pop takes it. group_done marks the last item of a reversed
// group, list_done the last item of the list.
// Config: cfg_data sets the group size (0 acts as 1, above MAX_GROUP acts as
// MAX_GROUP); cfg_ready is always high. Write it between groups or mid-group
// with no group draining; it applies from the next item.
// Path: the first result of a group reaches the result ports through the
// descriptor queue, the drain index registers, the buffer read and the result queue.
// Throughput: the input side takes an item whenever full is low, filling one
// bank while the other drains; the drain side can load the next group as it
// issues the last read of the current one, while the result queue has room.
// full rises when both banks hold groups not yet fully read. If pop stays low,
// the 4-entry result queue fills, draining stops, and full follows.
// Reset clears the flags, counts and pointers; buffer contents and drain index
// registers need no clearing, and the group size returns to 16.
module group_order_reverser #(
    parameter int MAX_GROUP = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [gor_pkg::VALUE_W-1:0] value,
    input  logic                               end_of_list,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [gor_pkg::VALUE_W-1:0] out_value,
    output logic                               group_done,
    output logic                               list_done,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gor_pkg::CFG_W-1:0]          cfg_data
);

    import gor_pkg::*;

    localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    logic               wr_en;
    logic [RAM_AW-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [RAM_AW-1:0]  rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic               desc_push;
    desc_t              desc_in;
    logic               desc_pop;
    logic               desc_avail;
    desc_t              desc_head;
    logic               release_bank;

    gor_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .value        (value),
        .end_of_list  (end_of_list),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .release_bank (release_bank),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .desc_push    (desc_push),
        .desc         (desc_in)
    );

    gor_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    gor_desc_q u_desc_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .push_desc (desc_in),
        .pop       (desc_pop),
        .avail     (desc_avail),
        .head      (desc_head)
    );

    gor_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc_avail   (desc_avail),
        .desc         (desc_head),
        .desc_pop     (desc_pop),
        .release_bank (release_bank),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .empty        (empty),
        .pop          (pop),
        .out_value    (out_value),
        .group_done   (group_done),
        .list_done    (list_done)
    );

endmodule

// ===== rtl/core/gor_ram.sv =====
module gor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/gor_front.sv =====
module gor_front #(
    parameter int MAX_GROUP = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [gor_pkg::VALUE_W-1:0] value,
    input  logic                             end_of_list,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gor_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             release_bank,
    output logic                             wr_en,
    output logic [$clog2(2 * (1 << ((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)))-1:0] wr_addr,
    output logic [gor_pkg::VALUE_W-1:0]      wr_data,
    output logic                             desc_push,
    output gor_pkg::desc_t                   desc
);

    import gor_pkg::*;

    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int SZ_W  = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

    logic [CFG_W-1:0] group_size_reg;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             bank_reg, bank_next;
    logic [1:0]       used_reg, used_next;
    logic             accept;
    logic             done;
    logic [SZ_W-1:0]  size_ext;
    logic [SZ_W-1:0]  eff_size;
    logic [SZ_W-1:0]  count_ext;

    assign cfg_ready = 1'b1;
    assign full      = (used_reg == 2'd2);
    assign accept    = push && !full;

    always_comb
    begin
        size_ext  = SZ_W'(group_size_reg);
        count_ext = SZ_W'(fill_reg) + SZ_W'(1);
        if (size_ext == '0)
        begin
            eff_size = SZ_W'(1);
        end
        else if (size_ext > SZ_W'(MAX_GROUP))
        begin
            eff_size = SZ_W'(MAX_GROUP);
        end
        else
        begin
            eff_size = size_ext;
        end
        done = accept && ((count_ext >= eff_size) || end_of_list);

        fill_next = fill_reg;
        bank_next = bank_reg;
        if (done)
        begin
            fill_next = '0;
            bank_next = !bank_reg;
        end
        else if (accept)
        begin
            fill_next = fill_reg + IDX_W'(1);
        end

        used_next = used_reg;
        case ({done, release_bank})
            2'b10:   used_next = used_reg + 2'd1;
            2'b01:   used_next = used_reg - 2'd1;
            default: used_next = used_reg;
        endcase
    end

    assign wr_en     = accept;
    assign wr_addr   = {bank_reg, fill_reg};
    assign wr_data   = value;
    assign desc_push = done;
    assign desc.bank = bank_reg;
    assign desc.top  = IDX_MAX_W'(fill_reg);
    assign desc.last = end_of_list;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RST;
            fill_reg       <= '0;
            bank_reg       <= 1'b0;
            used_reg       <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                group_size_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            used_reg <= used_next;
        end
    end

endmodule

// ===== rtl/core/gor_desc_q.sv =====
module gor_desc_q (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gor_pkg::desc_t push_desc,
    input  logic           pop,
    output logic           avail,
    output gor_pkg::desc_t head
);

    import gor_pkg::*;

    desc_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign avail = (count_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/gor_back.sv =====
module gor_back #(
    parameter int MAX_GROUP = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               desc_avail,
    input  gor_pkg::desc_t                     desc,
    output logic                               desc_pop,
    output logic                               release_bank,
    output logic [$clog2(2 * (1 << ((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)))-1:0] rd_addr,
    input  logic [gor_pkg::VALUE_W-1:0]        rd_data,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [gor_pkg::VALUE_W-1:0] out_value,
    output logic                               group_done,
    output logic                               list_done
);

    import gor_pkg::*;

    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW = $clog2(OQ_DEPTH);

    logic               active_reg, active_next;
    logic               bank_reg, bank_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               last_reg, last_next;
    logic               inflight_reg;
    tag_t               tag_reg;
    logic [VALUE_W-1:0] oq_value_reg [OQ_DEPTH];
    tag_t               oq_tag_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   oq_wr_reg;
    logic [OQ_AW-1:0]   oq_rd_reg;
    logic [OQ_AW:0]     oq_count_reg, oq_count_next;
    logic               credit;
    logic               issue;
    logic               tail;
    logic               out_take;

    assign credit   = (oq_count_reg + (OQ_AW + 1)'(inflight_reg)) < (OQ_AW + 1)'(OQ_DEPTH);
    assign issue    = active_reg && credit;
    assign tail     = (idx_reg == '0);
    assign desc_pop = desc_avail && (!active_reg || (issue && tail));
    assign release_bank = issue && tail;
    assign rd_addr  = {bank_reg, idx_reg};

    assign empty      = (oq_count_reg == '0);
    assign out_take   = pop && !empty;
    assign out_value  = oq_value_reg[oq_rd_reg];
    assign group_done = oq_tag_reg[oq_rd_reg].tail;
    assign list_done  = oq_tag_reg[oq_rd_reg].last;

    always_comb
    begin
        active_next = active_reg;
        bank_next   = bank_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        if (desc_pop)
        begin
            active_next = 1'b1;
            bank_next   = desc.bank;
            idx_next    = desc.top[IDX_W-1:0];
            last_next   = desc.last;
        end
        else if (issue)
        begin
            if (tail)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - IDX_W'(1);
            end
        end

        case ({inflight_reg, out_take})
            2'b10:   oq_count_next = oq_count_reg + (OQ_AW + 1)'(1);
            2'b01:   oq_count_next = oq_count_reg - (OQ_AW + 1)'(1);
            default: oq_count_next = oq_count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            tag_reg.tail <= tail;
            tag_reg.last <= tail && last_reg;
        end
        if (inflight_reg)
        begin
            oq_value_reg[oq_wr_reg] <= rd_data;
            oq_tag_reg[oq_wr_reg]   <= tag_reg;
        end
        bank_reg <= bank_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            inflight_reg <= 1'b0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            inflight_reg <= issue;
            if (inflight_reg)
            begin
                oq_wr_reg <= oq_wr_reg + OQ_AW'(1);
            end
            if (out_take)
            begin
                oq_rd_reg <= oq_rd_reg + OQ_AW'(1);
            end
            oq_count_reg <= oq_count_next;
        end
    end

endmodule

// ===== rtl/core/gor_checker.sv =====
`include "group_order_reverser_assert.svh"

module gor_port_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               full,
    input logic                               empty,
    input logic                               pop,
    input logic signed [gor_pkg::VALUE_W-1:0] out_value,
    input logic                               group_done,
    input logic                               list_done
);

    `GOR_ASSERT_IMP(a_list_ends_group, clk, rst_n, !empty && list_done, group_done)
    `GOR_ASSERT_IMP(a_reset_state, clk, rst_n, $rose(rst_n), empty && !full)
    `GOR_ASSERT_NXT(a_result_holds, clk, rst_n, !empty && !pop, !empty)
    `GOR_ASSERT_NXT(a_payload_holds, clk, rst_n, !empty && !pop,
        $stable(out_value) && $stable(group_done) && $stable(list_done))

endmodule

bind group_order_reverser gor_port_checker u_gor_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_value  (out_value),
    .group_done (group_done),
    .list_done  (list_done)
);
